/* hdl/sws_pkg.sv */
package sws_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int REQ_BITS    = 2;
  localparam int VALUE_BITS  = 32;
  localparam int VAL_EXT_BITS = 64;
  localparam int STATUS_BITS = 2;
  localparam int POS_BITS    = 5;
  localparam int OCC_BITS    = 5;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

/* hdl/sws_ram.sv */
module sws_ram #(
  parameter int DEPTH     = sws_pkg::DEPTH_DEF,
  parameter int WORD_BITS = sws_pkg::WORD_BITS_DEF,
  localparam int AW       = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/stack_with_search_core.sv */
// Bounded LIFO stack of signed words with a search request; one result per
// request. Entries sit in a single-port-write, single-port-read RAM with a
// registered read. Push, pop and the unused request code are answered straight
// from the idle state. A search walks the stack from the top, one RAM read per
// cycle, and stops at the first match or after the bottom entry. The result
// sits in an output register; the next request is taken once the core is idle
// and that register is empty or being drained in the same cycle.
module stack_with_search_core #(
  parameter int DEPTH     = sws_pkg::DEPTH_DEF,
  parameter int WORD_BITS = sws_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sws_pkg::REQ_BITS-1:0]         in_req_type,
  input  logic signed [sws_pkg::VALUE_BITS-1:0] in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sws_pkg::STATUS_BITS-1:0]      out_status,
  output logic                                 out_found,
  output logic [sws_pkg::POS_BITS-1:0]         out_position,
  output logic [sws_pkg::OCC_BITS-1:0]         out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > sws_pkg::POS_BITS) ? CW : sws_pkg::POS_BITS;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SRCH = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [WORD_BITS-1:0] key_r, key_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [sws_pkg::STATUS_BITS-1:0]  out_status_r, out_status_nxt;
  logic                             out_found_r, out_found_nxt;
  logic [sws_pkg::POS_BITS-1:0]     out_pos_r, out_pos_nxt;
  logic [sws_pkg::OCC_BITS-1:0]     out_occ_r, out_occ_nxt;

  logic [sws_pkg::VAL_EXT_BITS-1:0] value_ext;
  logic [WORD_BITS-1:0]             word;
  logic [CW-1:0]                    count_m1;
  logic [CW-1:0]                    count_p1;
  logic [PW-1:0]                    pos_ext;
  logic [PW-1:0]                    occ_ext;
  logic [PW-1:0]                    occ_nxt_ext;
  logic                             accept;
  logic                             wr_en;
  logic [AW-1:0]                    rd_addr;
  logic [WORD_BITS-1:0]             rd_data;

  assign value_ext = {{(sws_pkg::VAL_EXT_BITS - sws_pkg::VALUE_BITS){in_value[31]}},
                      in_value};
  assign word      = value_ext[WORD_BITS-1:0];
  assign count_m1  = count_r - CW'(1);
  assign count_p1  = count_r + CW'(1);
  assign pos_ext   = PW'(pos_r);
  assign occ_ext   = PW'(count_r);

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Idle: prefetch the top entry so a search can compare on its first cycle
  assign rd_addr = (state_r == S_SRCH) ? (idx_r - AW'(1)) : count_m1[AW-1:0];

  sws_ram #(
    .DEPTH    (DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(word),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_pos_nxt    = out_pos_r;
    out_occ_nxt    = out_occ_r;
    occ_nxt_ext    = occ_ext;
    wr_en          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sws_pkg::ST_DONE;
          out_found_nxt  = 1'b0;
          out_pos_nxt    = '0;
          out_occ_nxt    = occ_ext[sws_pkg::OCC_BITS-1:0];
          case (in_req_type)
            sws_pkg::REQ_PUSH: begin
              if (count_r >= CW'(DEPTH)) begin
                out_status_nxt = sws_pkg::ST_FULL;
              end else begin
                wr_en       = 1'b1;
                count_nxt   = count_p1;
                occ_nxt_ext = PW'(count_p1);
                out_occ_nxt = occ_nxt_ext[sws_pkg::OCC_BITS-1:0];
              end
            end
            sws_pkg::REQ_POP: begin
              if (count_r == '0) begin
                out_status_nxt = sws_pkg::ST_EMPTY;
              end else begin
                count_nxt   = count_m1;
                occ_nxt_ext = PW'(count_m1);
                out_occ_nxt = occ_nxt_ext[sws_pkg::OCC_BITS-1:0];
              end
            end
            sws_pkg::REQ_SEARCH: begin
              if (count_r != '0) begin
                // hold the result until the walk ends
                out_valid_nxt = 1'b0;
                key_nxt       = word;
                idx_nxt       = count_m1[AW-1:0];
                pos_nxt       = CW'(1);
                state_nxt     = S_SRCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH: begin
        if (rd_data == key_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sws_pkg::ST_DONE;
          out_found_nxt  = 1'b1;
          out_pos_nxt    = pos_ext[sws_pkg::POS_BITS-1:0];
          out_occ_nxt    = occ_ext[sws_pkg::OCC_BITS-1:0];
          state_nxt      = S_IDLE;
        end else if (idx_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sws_pkg::ST_DONE;
          out_found_nxt  = 1'b0;
          out_pos_nxt    = '0;
          out_occ_nxt    = occ_ext[sws_pkg::OCC_BITS-1:0];
          state_nxt      = S_IDLE;
        end else begin
          // advance one entry toward the bottom
          idx_nxt = idx_r - AW'(1);
          pos_nxt = pos_r + CW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_pos_r    <= out_pos_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_position  = out_pos_r;
  assign out_occupancy = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_srch_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> !out_valid_r)
    else $error("result register busy during search");

  a_srch_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |=> (count_r == $past(count_r)))
    else $error("fill count changed during search");

  a_srch_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (CW'(idx_r) < count_r))
    else $error("search index outside held entries");

endmodule

/* verif/stack_with_search_core_test.sv */
module stack_with_search_core_test;

  localparam int STACK_DEPTH    = sws_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int IDLE_PCT       = 11;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = STACK_DEPTH + 8;
  localparam logic [sws_pkg::REQ_BITS-1:0] REQ_SPARE = 2'd3;

  typedef struct packed {
    sws_pkg::status_t             status;
    logic                         found;
    logic [sws_pkg::POS_BITS-1:0] position;
    logic [sws_pkg::OCC_BITS-1:0] occupancy;
  } stack_result_t;

  // Mirror of the stack: applies each accepted request and queues the result it owes.
  class stack_tracker;
    logic signed [sws_pkg::VALUE_BITS-1:0] entries_m [STACK_DEPTH];
    int unsigned                           fill_m;
    stack_result_t                         pending_results [$];
    int unsigned                           mismatch_count;

    function new();
      fill_m = 0;
      mismatch_count = 0;
    endfunction

    function void note_request(logic [sws_pkg::REQ_BITS-1:0] req,
                               logic signed [sws_pkg::VALUE_BITS-1:0] word);
      stack_result_t res;
      res = '0;
      res.status = sws_pkg::ST_DONE;
      case (req)
        sws_pkg::REQ_PUSH: begin
          if (fill_m >= STACK_DEPTH) begin
            res.status = sws_pkg::ST_FULL;
          end else begin
            entries_m[fill_m] = word;
            fill_m++;
          end
        end
        sws_pkg::REQ_POP: begin
          if (fill_m == 0) res.status = sws_pkg::ST_EMPTY;
          else fill_m--;
        end
        sws_pkg::REQ_SEARCH: begin
          // walk from the top, stop at the first match
          for (int k = 0; k < fill_m; k++) begin
            if (entries_m[fill_m - 1 - k] == word) begin
              res.found = 1'b1;
              res.position = sws_pkg::POS_BITS'(k + 1);
              break;
            end
          end
        end
        default: ;
      endcase
      res.occupancy = sws_pkg::OCC_BITS'(fill_m);
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [sws_pkg::STATUS_BITS-1:0] status, logic found,
                               logic [sws_pkg::POS_BITS-1:0] position,
                               logic [sws_pkg::OCC_BITS-1:0] occupancy);
      stack_result_t exp;
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status=%0d found=%0d position=%0d %s%0d",
               status, found, position, "occupancy=", occupancy);
        mismatch_count++;
        return;
      end
      exp = pending_results.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatch_count++;
      end
      if (found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, found);
        mismatch_count++;
      end
      if (position !== exp.position) begin
        $error("position: expected %0d, got %0d", exp.position, position);
        mismatch_count++;
      end
      if (occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp.occupancy, occupancy);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [sws_pkg::REQ_BITS-1:0]           in_req_type = '0;
  logic signed [sws_pkg::VALUE_BITS-1:0]  in_value = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [sws_pkg::STATUS_BITS-1:0]        out_status;
  logic                                   out_found;
  logic [sws_pkg::POS_BITS-1:0]           out_position;
  logic [sws_pkg::OCC_BITS-1:0]           out_occupancy;

  stack_tracker                           stack_model;
  logic                                   calm_phase = 1'b0;
  int unsigned                            idle_cycles = 0;
  logic signed [sws_pkg::VALUE_BITS-1:0]  word_pool [8];

  stack_with_search_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_position (out_position),
    .out_occupancy(out_occupancy)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
  end

  // Note requests before checking results: a result never belongs to a request of the same edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) stack_model.note_request(in_req_type, in_value);
    if (rst_n && out_valid && out_ready)
      stack_model.check_result(out_status, out_found, out_position, out_occupancy);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold the transaction until it is taken; returns just after the accepting edge.
  task automatic send_request(input logic [sws_pkg::REQ_BITS-1:0] req,
                              input logic signed [sws_pkg::VALUE_BITS-1:0] word);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_for_results();
    do @(posedge clk); while (stack_model.pending_results.size() != 0);
  endtask

  function automatic logic signed [sws_pkg::VALUE_BITS-1:0] pick_word();
    if ($urandom_range(99) < 45) return word_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic signed [sws_pkg::VALUE_BITS-1:0] pick_key();
    int unsigned depth_now;
    int unsigned roll;
    depth_now = stack_model.fill_m;
    roll = $urandom_range(99);
    if (roll < 50 && depth_now > 0 && depth_now <= STACK_DEPTH)
      return stack_model.entries_m[$urandom_range(depth_now - 1)];
    return pick_word();
  endfunction

  initial begin
    int unsigned                           sent;
    int unsigned                           roll;
    logic                                  growing;
    logic [sws_pkg::REQ_BITS-1:0]          req;
    logic signed [sws_pkg::VALUE_BITS-1:0] word;

    stack_model = new();
    word_pool[0] = 32'sh8000_0000;
    word_pool[1] = 32'sh7fff_ffff;
    word_pool[2] = 32'sh0;
    word_pool[3] = -32'sd1;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, unused code, extremes, fill to the top and overflow
    send_request(sws_pkg::REQ_POP, 32'sd0);
    send_request(sws_pkg::REQ_SEARCH, 32'sd0);
    send_request(REQ_SPARE, 32'sd5);
    send_request(sws_pkg::REQ_PUSH, 32'sh8000_0000);
    send_request(sws_pkg::REQ_PUSH, 32'sh7fff_ffff);
    send_request(sws_pkg::REQ_PUSH, 32'sd0);
    send_request(sws_pkg::REQ_PUSH, -32'sd1);
    send_request(sws_pkg::REQ_SEARCH, 32'sh8000_0000);
    send_request(sws_pkg::REQ_SEARCH, -32'sd1);
    send_request(sws_pkg::REQ_SEARCH, 32'sd12345);
    send_request(sws_pkg::REQ_POP, 32'sh7fff_ffff);
    for (int i = 0; i < STACK_DEPTH - 3; i++)
      send_request(sws_pkg::REQ_PUSH, (i % 2) ? 32'sh7fff_ffff : signed'($urandom));
    send_request(sws_pkg::REQ_PUSH, 32'sd77);
    send_request(sws_pkg::REQ_SEARCH, 32'sh8000_0000);
    send_request(sws_pkg::REQ_SEARCH, 32'sh7fff_ffff);
    send_request(REQ_SPARE, -32'sd1);

    // random: drift up or down so the stack hits both full and empty often
    sent = 0;
    growing = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(39) == 0) growing = ~growing;
      calm_phase <= (sent >= 700 && sent < 1100);
      roll = $urandom_range(99);
      if (roll < 3) req = REQ_SPARE;
      else if (roll < 30) req = sws_pkg::REQ_SEARCH;
      else if (roll < (growing ? 85 : 45)) req = sws_pkg::REQ_PUSH;
      else req = sws_pkg::REQ_POP;
      word = (req == sws_pkg::REQ_SEARCH) ? pick_key() : pick_word();
      send_request(req, word);
      if (req != REQ_SPARE) sent++;
      if (sent == 500 || sent == 1200 || sent == 1700) begin
        in_valid <= 1'b0;
        wait_for_results();
      end else if (!(sent >= 700 && sent < 1100) && $urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    calm_phase <= 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (stack_model.mismatch_count == 0 && stack_model.pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      if (stack_model.pending_results.size() != 0)
        $error("%0d results never arrived", stack_model.pending_results.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
